// ===== src/lru_block_cache_directory_unit_defines.svh =====
// Assertion macros shared by the directory RTL.
`ifndef LRU_BLOCK_CACHE_DIRECTORY_UNIT_DEFINES_SVH
`define LRU_BLOCK_CACHE_DIRECTORY_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked property, masked while reset is asserted.
`define LBCD_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Checked property, live during reset as well.
`define LBCD_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LBCD_ASSERT(label, clk, rstn, prop, msg)
`define LBCD_ASSERT_NR(label, clk, prop, msg)
`endif

`endif

// ===== src/lbcd_pkg.sv =====
package lbcd_pkg;

    localparam int unsigned DEF_ENTRIES     = 16;
    localparam int unsigned DEF_COORD_BITS  = 16;
    localparam int unsigned DEF_HANDLE_BITS = 32;

    typedef enum logic [1:0] {
        KIND_LOOKUP = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_CLEAR  = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

endpackage

// ===== src/lbcd_ram.sv =====
module lbcd_ram
    import lbcd_pkg::*;
#(
    parameter int unsigned DEPTH = DEF_ENTRIES,
    parameter int unsigned WIDTH = 3 * DEF_COORD_BITS + DEF_HANDLE_BITS
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/lru_block_cache_directory_unit.sv =====
// Fully associative block directory with least-recently-used replacement.
//
// Input channel (s_*): one request per valid/ready handshake. s_kind selects
// lookup, insert or clear; the key is {s_coord_x, s_coord_y, s_coord_z} and
// s_block_handle is the payload stored by an insert.
// Result channel (m_*): exactly one result per request, in request order.
//
// Entries sit in one memory ordered by recency: slot 0 is the most recent,
// slot count-1 the least recent. A lookup scans slots from 0 upward, so the
// first match is also the most recent duplicate; a hit then shifts the newer
// slots down by one and rewrites the found entry into slot 0. An insert
// shifts every slot down by one (the last slot falls out as the victim when
// the store is full) and writes the new entry into slot 0.
// Each request is worked through the single read port of the entry memory:
// insert shifts then writes slot 0 (no shift when empty); a lookup scans,
// and a hit moves its entry to slot 0; clear and unused kind do neither.
// One request is in flight at a time; s_ready is high only between requests.
// Reset empties the directory at once, with no clearing pass.
// A stalled receiver holds the result register; the next request is still
// taken and worked on, and waits only for the result register to drain.
module lru_block_cache_directory_unit
    import lbcd_pkg::*;
#(
    parameter int unsigned ENTRIES     = DEF_ENTRIES,
    parameter int unsigned COORD_BITS  = DEF_COORD_BITS,
    parameter int unsigned HANDLE_BITS = DEF_HANDLE_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [1:0]             s_kind,
    input  logic [COORD_BITS-1:0]  s_coord_x,
    input  logic [COORD_BITS-1:0]  s_coord_y,
    input  logic [COORD_BITS-1:0]  s_coord_z,
    input  logic [HANDLE_BITS-1:0] s_block_handle,

    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_hit,
    output logic [HANDLE_BITS-1:0] m_found_handle,
    output logic                   m_evicted,
    output logic [HANDLE_BITS-1:0] m_victim_handle
);

`include "lru_block_cache_directory_unit_defines.svh"

    localparam int unsigned KEY_W = 3 * COORD_BITS;
    localparam int unsigned ENT_W = KEY_W + HANDLE_BITS;
    localparam int unsigned IDX_W = $clog2(ENTRIES);
    localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES);

    typedef enum logic [2:0] {
        ST_IDLE,   // wait for a request
        ST_SCAN,   // compare slots 0 upward
        ST_SHIFT,  // move slots down by one, top first
        ST_PUT,    // write the most recent entry into slot 0
        ST_FIN     // hand the result to the output register
    } state_t;

    // Control state
    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] idx_reg, idx_next;     // next slot to read
    logic             pend_reg, pend_next;   // memory read data is live
    logic [IDX_W-1:0] pidx_reg, pidx_next;   // slot that the read data came from

    // Request and result payload
    kind_t             kind_reg, kind_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [HANDLE_BITS-1:0] handle_reg, handle_next;
    logic [ENT_W-1:0]  hold_reg, hold_next;  // entry found by a lookup
    logic              res_hit_reg, res_hit_next;
    logic [HANDLE_BITS-1:0] res_found_reg, res_found_next;
    logic              res_evict_reg, res_evict_next;
    logic [HANDLE_BITS-1:0] res_victim_reg, res_victim_next;

    // Output register
    logic              m_valid_reg, m_valid_next;
    logic              m_hit_reg, m_hit_next;
    logic [HANDLE_BITS-1:0] m_found_reg, m_found_next;
    logic              m_evict_reg, m_evict_next;
    logic [HANDLE_BITS-1:0] m_victim_reg, m_victim_next;

    // Entry memory port
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [ENT_W-1:0] mem_wdata;
    logic [IDX_W-1:0] mem_raddr;
    logic [ENT_W-1:0] mem_rdata;

    logic [KEY_W-1:0]       rd_key;
    logic [HANDLE_BITS-1:0] rd_handle;
    logic                   key_match;
    logic [CNT_W-1:0]       pidx_ext;
    logic [CNT_W-1:0]       last_slot;

    lbcd_ram #(
        .DEPTH (ENTRIES),
        .WIDTH (ENT_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign rd_key    = mem_rdata[ENT_W-1:HANDLE_BITS];
    assign rd_handle = mem_rdata[HANDLE_BITS-1:0];
    assign key_match = (rd_key == key_reg);
    assign pidx_ext  = CNT_W'(pidx_reg);
    assign last_slot = count_reg - CNT_W'(1);

    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_hit           = m_hit_reg;
    assign m_found_handle  = m_found_reg;
    assign m_evicted       = m_evict_reg;
    assign m_victim_handle = m_victim_reg;

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        pend_next       = pend_reg;
        pidx_next       = pidx_reg;
        kind_next       = kind_reg;
        key_next        = key_reg;
        handle_next     = handle_reg;
        hold_next       = hold_reg;
        res_hit_next    = res_hit_reg;
        res_found_next  = res_found_reg;
        res_evict_next  = res_evict_reg;
        res_victim_next = res_victim_reg;
        m_valid_next    = m_valid_reg;
        m_hit_next      = m_hit_reg;
        m_found_next    = m_found_reg;
        m_evict_next    = m_evict_reg;
        m_victim_next   = m_victim_reg;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = mem_rdata;
        mem_raddr       = idx_reg;

        // Drop the result once the receiver takes it
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    kind_next       = kind_t'(s_kind);
                    key_next        = {s_coord_x, s_coord_y, s_coord_z};
                    handle_next     = s_block_handle;
                    res_hit_next    = 1'b0;
                    res_found_next  = '0;
                    res_evict_next  = 1'b0;
                    res_victim_next = '0;
                    pend_next       = 1'b0;
                    unique case (kind_t'(s_kind))
                        KIND_LOOKUP: begin
                            idx_next = '0;
                            if (count_reg == '0) begin
                                state_next = ST_FIN;
                            end else begin
                                state_next = ST_SCAN;
                            end
                        end
                        KIND_INSERT: begin
                            res_hit_next = 1'b1;
                            idx_next     = IDX_W'(last_slot);
                            if (count_reg == '0) begin
                                state_next = ST_PUT;
                            end else begin
                                state_next = ST_SHIFT;
                            end
                        end
                        KIND_CLEAR: begin
                            count_next = '0;
                            state_next = ST_FIN;
                        end
                        KIND_NONE: begin
                            state_next = ST_FIN;
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                priority if (pend_reg && key_match) begin
                    // Hit: the first match from slot 0 is the most recent one
                    res_hit_next   = 1'b1;
                    res_found_next = rd_handle;
                    hold_next      = mem_rdata;
                    pend_next      = 1'b0;
                    if (pidx_reg == '0) begin
                        state_next = ST_PUT;
                    end else begin
                        idx_next   = pidx_reg - IDX_W'(1);
                        state_next = ST_SHIFT;
                    end
                end else if (pend_reg && pidx_ext == last_slot) begin
                    pend_next  = 1'b0;
                    state_next = ST_FIN;
                end else begin
                    pend_next = 1'b1;
                    pidx_next = idx_reg;
                    idx_next  = idx_reg + IDX_W'(1);
                end
            end

            ST_SHIFT: begin
                if (pend_reg) begin
                    if (pidx_ext + CNT_W'(1) == FULL_CNT) begin
                        // Last slot falls out of a full store
                        res_evict_next  = 1'b1;
                        res_victim_next = rd_handle;
                    end else begin
                        mem_we    = 1'b1;
                        mem_waddr = pidx_reg + IDX_W'(1);
                        mem_wdata = mem_rdata;
                    end
                end
                if (pend_reg && pidx_reg == '0) begin
                    pend_next  = 1'b0;
                    state_next = ST_PUT;
                end else begin
                    pend_next = 1'b1;
                    pidx_next = idx_reg;
                    idx_next  = idx_reg - IDX_W'(1);
                end
            end

            ST_PUT: begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                if (kind_reg == KIND_INSERT) begin
                    mem_wdata = {key_reg, handle_reg};
                    if (count_reg != FULL_CNT) begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end else begin
                    mem_wdata = hold_reg;
                end
                state_next = ST_FIN;
            end

            ST_FIN: begin
                // Hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_hit_next    = res_hit_reg;
                    m_found_next  = res_found_reg;
                    m_evict_next  = res_evict_reg;
                    m_victim_next = res_victim_reg;
                    state_next    = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
        idx_reg        <= idx_next;
        pidx_reg       <= pidx_next;
        kind_reg       <= kind_next;
        key_reg        <= key_next;
        handle_reg     <= handle_next;
        hold_reg       <= hold_next;
        res_hit_reg    <= res_hit_next;
        res_found_reg  <= res_found_next;
        res_evict_reg  <= res_evict_next;
        res_victim_reg <= res_victim_next;
        m_hit_reg      <= m_hit_next;
        m_found_reg    <= m_found_next;
        m_evict_reg    <= m_evict_next;
        m_victim_reg   <= m_victim_next;
    end

    `LBCD_ASSERT(a_count_bound, aclk, aresetn, count_reg <= FULL_CNT, "entry count above capacity")
    `LBCD_ASSERT(a_evict_full, aclk, aresetn, (state_reg == ST_FIN && res_evict_reg) |-> (count_reg == FULL_CNT), "eviction from a store that is not full")
    `LBCD_ASSERT(a_scan_no_write, aclk, aresetn, (state_reg == ST_SCAN) |-> !mem_we, "memory write during key scan")
    `LBCD_ASSERT(a_scan_in_range, aclk, aresetn, (state_reg == ST_SCAN && pend_reg) |-> (pidx_ext < count_reg), "scan read beyond filled slots")
    `LBCD_ASSERT_NR(a_reset_idle, aclk, !aresetn |=> (state_reg == ST_IDLE && !m_valid_reg), "not idle after reset")

endmodule
